@@ src/txi_pkg.sv @@
// Package for the triangle x-axis intersection block.
// Holds the result kind codes and default widths; no dependencies.
package txi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int TOL_WIDTH = 31;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_SEGMENT = 2'd2;
   localparam logic [1:0] KIND_COINCIDENT = 2'd3;

endpackage

@@ src/txi_classify.sv @@
// Classification stage: classes each vertex against the tolerance band and
// selects what each result end is built from. Depends on txi_pkg.
module txi_classify #(
   parameter int COORD_WIDTH = txi_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [txi_pkg::TOL_WIDTH-1:0] tolerance,
   input  logic signed [COORD_WIDTH-1:0] vx [3],
   input  logic signed [COORD_WIDTH-1:0] vy [3],
   output logic [1:0]                    kind_ff,
   output logic                          cross_ff [2],
   output logic signed [COORD_WIDTH-1:0] px_ff [2],
   output logic signed [COORD_WIDTH-1:0] py_ff [2],
   output logic signed [COORD_WIDTH-1:0] qx_ff [2],
   output logic signed [COORD_WIDTH-1:0] qy_ff [2]
);

   localparam int TW = ((COORD_WIDTH > txi_pkg::TOL_WIDTH) ?
                        COORD_WIDTH : txi_pkg::TOL_WIDTH) + 2;

   logic [1:0]                    kind_in;
   logic                          cross_in [2];
   logic signed [COORD_WIDTH-1:0] px_in [2];
   logic signed [COORD_WIDTH-1:0] py_in [2];
   logic signed [COORD_WIDTH-1:0] qx_in [2];
   logic signed [COORD_WIDTH-1:0] qy_in [2];

   always_comb begin
      logic signed [TW-1:0] tol_s;
      logic signed [TW-1:0] y_s;
      logic                 pos [3];
      logic                 neg [3];
      logic                 on [3];
      logic [1:0]           n_on;
      logic [1:0]           n_pos;
      logic [1:0]           n_neg;
      logic [1:0]           lone;
      logic [1:0]           z;
      logic [1:0]           o1;
      logic [1:0]           o2;
      logic [1:0]           fa;
      logic [1:0]           fb;
      logic                 fa_set;
      tol_s = TW'({{(TW - txi_pkg::TOL_WIDTH){1'b0}}, tolerance});
      n_on = 2'd0;
      n_pos = 2'd0;
      n_neg = 2'd0;
      for (int i = 0; i < 3; i++) begin
         y_s = TW'({{(TW - COORD_WIDTH){vy[i][COORD_WIDTH-1]}}, vy[i]});
         pos[i] = y_s > tol_s;
         neg[i] = y_s < -tol_s;
         on[i] = !pos[i] && !neg[i];
         n_on = n_on + {1'b0, on[i]};
         n_pos = n_pos + {1'b0, pos[i]};
         n_neg = n_neg + {1'b0, neg[i]};
      end
      lone = 2'd0;
      z = 2'd0;
      o1 = 2'd0;
      o2 = 2'd0;
      fa = 2'd0;
      fb = 2'd0;
      fa_set = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if ((n_pos == 2'd1 && pos[i]) || (n_neg == 2'd1 && neg[i])) begin
            lone = 2'(i);
         end
         if (on[i]) begin
            z = 2'(i);
            if (!fa_set) begin
               fa = 2'(i);
               fa_set = 1'b1;
            end else begin
               fb = 2'(i);
            end
         end
      end
      kind_in = txi_pkg::KIND_NONE;
      for (int k = 0; k < 2; k++) begin
         cross_in[k] = 1'b0;
         px_in[k] = '0;
         py_in[k] = '0;
         qx_in[k] = '0;
         qy_in[k] = '0;
      end
      if (n_on == 2'd3) begin
         kind_in = txi_pkg::KIND_COINCIDENT;
      end else if (n_on == 2'd0) begin
         if (n_pos != 2'd0 && n_neg != 2'd0) begin
            o1 = (lone == 2'd0) ? 2'd1 : 2'd0;
            o2 = (lone == 2'd2) ? 2'd1 : 2'd2;
            kind_in = txi_pkg::KIND_SEGMENT;
            cross_in[0] = 1'b1;
            cross_in[1] = 1'b1;
            px_in[0] = vx[lone];
            py_in[0] = vy[lone];
            qx_in[0] = vx[o1];
            qy_in[0] = vy[o1];
            px_in[1] = vx[lone];
            py_in[1] = vy[lone];
            qx_in[1] = vx[o2];
            qy_in[1] = vy[o2];
         end
      end else if (n_on == 2'd1) begin
         o1 = (z == 2'd0) ? 2'd1 : 2'd0;
         o2 = (z == 2'd2) ? 2'd1 : 2'd2;
         if (pos[o1] == pos[o2]) begin
            kind_in = txi_pkg::KIND_POINT;
            px_in[0] = vx[z];
            py_in[0] = vy[z];
            px_in[1] = vx[z];
            py_in[1] = vy[z];
         end else begin
            kind_in = txi_pkg::KIND_SEGMENT;
            if (z == 2'd0) begin
               px_in[0] = vx[z];
               py_in[0] = vy[z];
               cross_in[1] = 1'b1;
               px_in[1] = vx[o1];
               py_in[1] = vy[o1];
               qx_in[1] = vx[o2];
               qy_in[1] = vy[o2];
            end else begin
               cross_in[0] = 1'b1;
               px_in[0] = vx[o1];
               py_in[0] = vy[o1];
               qx_in[0] = vx[o2];
               qy_in[0] = vy[o2];
               px_in[1] = vx[z];
               py_in[1] = vy[z];
            end
         end
      end else begin
         kind_in = txi_pkg::KIND_SEGMENT;
         px_in[0] = vx[fa];
         py_in[0] = vy[fa];
         px_in[1] = vx[fb];
         py_in[1] = vy[fb];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff <= kind_in;
         for (int k = 0; k < 2; k++) begin
            cross_ff[k] <= cross_in[k];
            px_ff[k] <= px_in[k];
            py_ff[k] <= py_in[k];
            qx_ff[k] <= qx_in[k];
            qy_ff[k] <= qy_in[k];
         end
      end
   end

endmodule

@@ src/txi_cross_lane.sv @@
// One result end: a multiply stage, a one-bit-per-stage divider and a
// rounding stage that give the x-axis crossing of an edge. Depends on txi_pkg.
module txi_cross_lane #(
   parameter int COORD_WIDTH = txi_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic [COORD_WIDTH+1:0]        en,
   input  logic                          is_cross,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic signed [COORD_WIDTH-1:0] qx,
   input  logic signed [COORD_WIDTH-1:0] qy,
   output logic signed [COORD_WIDTH-1:0] x_ff,
   output logic signed [COORD_WIDTH-1:0] y_ff
);

   localparam int W = COORD_WIDTH;

   logic [W-1:0]   rem_ff [W+1];
   logic [W-1:0]   lo_ff [W+1];
   logic [W-1:0]   quo_ff [W+1];
   logic [W:0]     den_ff [W+1];
   logic           neg_ff [W+1];
   logic           cross_ff [W+1];
   logic [W-1:0]   px_ff [W+1];
   logic [W-1:0]   py_ff [W+1];

   logic [W-1:0]   a_in;
   logic [W:0]     den_in;
   logic           neg_in;
   logic [W-1:0]   dm_in;
   logic [2*W-1:0] prod_in;

   always_comb begin
      logic [W-1:0] b_mag;
      a_in = py[W-1] ? (W'(0) - W'(py)) : W'(py);
      b_mag = qy[W-1] ? (W'(0) - W'(qy)) : W'(qy);
      den_in = {1'b0, a_in} + {1'b0, b_mag};
      neg_in = qx < px;
      dm_in = neg_in ? (W'(px) - W'(qx)) : (W'(qx) - W'(px));
      prod_in = (2*W)'(dm_in) * (2*W)'(a_in);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= prod_in[2*W-1:W];
         lo_ff[0] <= prod_in[W-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den_in;
         neg_ff[0] <= neg_in;
         cross_ff[0] <= is_cross;
         px_ff[0] <= W'(px);
         py_ff[0] <= W'(py);
      end
   end

   for (genvar j = 1; j <= W; j++) begin : g_div
      logic [W:0] t_in;
      logic       ge_in;
      assign t_in = {rem_ff[j-1], lo_ff[j-1][W-1]};
      assign ge_in = t_in >= den_ff[j-1];

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= ge_in ? W'(t_in - den_ff[j-1]) : t_in[W-1:0];
            lo_ff[j] <= {lo_ff[j-1][W-2:0], 1'b0};
            quo_ff[j] <= {quo_ff[j-1][W-2:0], ge_in};
            den_ff[j] <= den_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            cross_ff[j] <= cross_ff[j-1];
            px_ff[j] <= px_ff[j-1];
            py_ff[j] <= py_ff[j-1];
         end
      end
   end

   logic [W-1:0] x_in;
   logic [W-1:0] y_in;

   always_comb begin
      logic         rnz;
      logic [W-1:0] f;
      logic [W-1:0] base;
      rnz = rem_ff[W] != '0;
      f = neg_ff[W] ? (W'(0) - quo_ff[W] - W'(rnz)) : quo_ff[W];
      base = px_ff[W] + f;
      if (rnz && base[W-1]) begin
         base = base + W'(1);
      end
      if (cross_ff[W]) begin
         x_in = base;
         y_in = '0;
      end else begin
         x_in = px_ff[W];
         y_in = py_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[W+1]) begin
         x_ff <= signed'(x_in);
         y_ff <= signed'(y_in);
      end
   end

endmodule

@@ src/triangle_x_axis_intersect.sv @@
// Triangle against x-axis intersection, top level. Uses txi_pkg,
// txi_classify and txi_cross_lane.
// One triangle transfer per cycle while the response side is not stalled, set
// by a divider with one quotient bit per stage.
// Each stage holds its item only while the stage after it is full and stalled.
// Synchronous active-high reset empties the pipeline and sets tolerance to 1.
module triangle_x_axis_intersect #(
   parameter int COORD_WIDTH = txi_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [txi_pkg::TOL_WIDTH-1:0] csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_ax,
   input  logic signed [COORD_WIDTH-1:0] req_ay,
   input  logic signed [COORD_WIDTH-1:0] req_bx,
   input  logic signed [COORD_WIDTH-1:0] req_by,
   input  logic signed [COORD_WIDTH-1:0] req_cx,
   input  logic signed [COORD_WIDTH-1:0] req_cy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic signed [COORD_WIDTH-1:0] rsp_start_x,
   output logic signed [COORD_WIDTH-1:0] rsp_start_y,
   output logic signed [COORD_WIDTH-1:0] rsp_end_x,
   output logic signed [COORD_WIDTH-1:0] rsp_end_y
);

   localparam int W = COORD_WIDTH;
   localparam int N = W + 4;

   logic [txi_pkg::TOL_WIDTH-1:0] tolerance_ff;
   logic [N-1:0]                  valid_ff;
   logic [N:0]                    en;
   logic [1:0]                    kind_ff [W+3];

   logic signed [W-1:0] vx [3];
   logic signed [W-1:0] vy [3];
   logic                c_cross [2];
   logic signed [W-1:0] c_px [2];
   logic signed [W-1:0] c_py [2];
   logic signed [W-1:0] c_qx [2];
   logic signed [W-1:0] c_qy [2];
   logic signed [W-1:0] lx [2];
   logic signed [W-1:0] ly [2];

   assign vx[0] = req_ax;
   assign vy[0] = req_ay;
   assign vx[1] = req_bx;
   assign vy[1] = req_by;
   assign vx[2] = req_cx;
   assign vy[2] = req_cy;

   always_comb begin
      en[N] = rsp_ready;
      for (int k = N - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= txi_pkg::TOL_WIDTH'(1);
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            tolerance_ff <= csr_wr_data;
         end
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < N; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   txi_classify #(
      .COORD_WIDTH(W)
   ) u_classify (
      .clock     (clock),
      .en        (en[0]),
      .tolerance (tolerance_ff),
      .vx        (vx),
      .vy        (vy),
      .kind_ff   (kind_ff[0]),
      .cross_ff  (c_cross),
      .px_ff     (c_px),
      .py_ff     (c_py),
      .qx_ff     (c_qx),
      .qy_ff     (c_qy)
   );

   for (genvar j = 1; j <= W + 2; j++) begin : g_kind
      always_ff @(posedge clock) begin
         if (en[j]) begin
            kind_ff[j] <= kind_ff[j-1];
         end
      end
   end

   for (genvar k = 0; k < 2; k++) begin : g_lane
      txi_cross_lane #(
         .COORD_WIDTH(W)
      ) u_lane (
         .clock    (clock),
         .en       (en[W+2:1]),
         .is_cross (c_cross[k]),
         .px       (c_px[k]),
         .py       (c_py[k]),
         .qx       (c_qx[k]),
         .qy       (c_qy[k]),
         .x_ff     (lx[k]),
         .y_ff     (ly[k])
      );
   end

   logic swap_in;
   assign swap_in = (kind_ff[W+2] == txi_pkg::KIND_SEGMENT) && (lx[0] > lx[1]);

   always_ff @(posedge clock) begin
      if (en[N-1]) begin
         rsp_kind <= kind_ff[W+2];
         rsp_start_x <= swap_in ? lx[1] : lx[0];
         rsp_start_y <= swap_in ? ly[1] : ly[0];
         rsp_end_x <= swap_in ? lx[0] : lx[1];
         rsp_end_y <= swap_in ? ly[0] : ly[1];
      end
   end

endmodule
